@@ rtl/core/bppc_pkg.sv @@
// bppc_pkg: shared constants and types for the ball patch pixel classifier
// used by every module under rtl/core; no dependencies
`timescale 1ns / 1ps

package bppc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SIZE_CFG_W = 11;
    localparam int LEVEL_W    = 8;
    localparam int LIMIT_W    = 16;
    localparam int TOTAL_W    = 21;
    localparam int KIND_W     = 2;
    localparam int CHAN_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DARK_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CUE_LIMIT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_LIMIT = 3'd6;

    localparam logic [SIZE_CFG_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [SIZE_CFG_W-1:0] RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [LEVEL_W-1:0]    RST_BRIGHT_LEVEL = 8'd100;
    localparam logic [LEVEL_W-1:0]    RST_DARK_LEVEL   = 8'd10;
    localparam logic [LIMIT_W-1:0]    RST_DARK_LIMIT   = 16'd12452;
    localparam logic [LIMIT_W-1:0]    RST_CUE_LIMIT    = 16'd13107;
    localparam logic [LIMIT_W-1:0]    RST_STRIPE_LIMIT = 16'd3277;

    localparam logic [KIND_W-1:0] KIND_EIGHT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CUE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRIPED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SOLID   = 2'd3;

    typedef enum logic [2:0] {
        CLS_IDLE,
        CLS_AREA,
        CLS_PDARK,
        CLS_TDARK,
        CLS_TCUE,
        CLS_TSTRIPE,
        CLS_HOLD
    } cls_state_t;

endpackage

@@ rtl/core/bppc_front.sv @@
// bppc_front: accepts pixel words, thresholds them and tracks the raster position
// depends on bppc_pkg; feeds bppc_fifo
`timescale 1ns / 1ps

module bppc_front import bppc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int SW = $clog2(MAX_WIDTH + 1),
    localparam int SH = $clog2(MAX_HEIGHT + 1),
    localparam int DW = SW + SH + 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [3*CHAN_W-1:0]   s_tdata,
    input  logic [SIZE_CFG_W-1:0] frame_width,
    input  logic [SIZE_CFG_W-1:0] frame_height,
    input  logic [LEVEL_W-1:0]    bright_level,
    input  logic [LEVEL_W-1:0]    dark_level,
    output logic                  q_push,
    input  logic                  q_ready,
    output logic [DW-1:0]         q_data
);

    localparam int FCW = $clog2(MAX_WIDTH);
    localparam int FRW = $clog2(MAX_HEIGHT);

    logic [FCW-1:0] col_reg;
    logic [FRW-1:0] row_reg;
    logic [SW-1:0]  w_reg;
    logic [SH-1:0]  h_reg;
    logic [SW-1:0]  cur_w;
    logic [SH-1:0]  cur_h;
    logic [CHAN_W-1:0] blue, green, red;
    logic first, bright, dark, col_end, row_end;

    function automatic logic [SW-1:0] clamp_w(input logic [SIZE_CFG_W-1:0] v);
        if (v == '0) begin
            return SW'(1);
        end else if (32'(v) > 32'(MAX_WIDTH)) begin
            return SW'(MAX_WIDTH);
        end
        return SW'(v);
    endfunction

    function automatic logic [SH-1:0] clamp_h(input logic [SIZE_CFG_W-1:0] v);
        if (v == '0) begin
            return SH'(1);
        end else if (32'(v) > 32'(MAX_HEIGHT)) begin
            return SH'(MAX_HEIGHT);
        end
        return SH'(v);
    endfunction

    assign blue  = s_tdata[CHAN_W-1:0];
    assign green = s_tdata[2*CHAN_W-1:CHAN_W];
    assign red   = s_tdata[3*CHAN_W-1:2*CHAN_W];

    assign first   = (col_reg == '0) && (row_reg == '0);
    assign cur_w   = first ? clamp_w(frame_width) : w_reg;
    assign cur_h   = first ? clamp_h(frame_height) : h_reg;
    assign bright  = (blue >= bright_level) && (green >= bright_level) && (red >= bright_level);
    assign dark    = (blue < dark_level) || (green < dark_level) || (red < dark_level);
    assign col_end = SW'(col_reg) == cur_w - SW'(1);
    assign row_end = SH'(row_reg) == cur_h - SH'(1);

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;
    assign q_data   = {cur_h, cur_w, dark, bright};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (q_push) begin
            if (col_end) begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_reg + FRW'(1);
            end else begin
                col_reg <= col_reg + FCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_push && first) begin
            w_reg <= cur_w;
            h_reg <= cur_h;
        end
    end

endmodule

@@ rtl/core/bppc_fifo.sv @@
// bppc_fifo: short queue between the pixel front end and the opening engine
// depends on bppc_pkg
`timescale 1ns / 1ps

module bppc_fifo import bppc_pkg::*; #(
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    output logic          ready,
    input  logic [DW-1:0] wdata,
    output logic          valid,
    input  logic          pop,
    output logic [DW-1:0] rdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0] slot_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] fill_reg;

    assign ready = fill_reg != NW'(QUEUE_DEPTH);
    assign valid = fill_reg != '0;
    assign rdata = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            fill_reg <= fill_reg + NW'(push) - NW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/core/bppc_open.sv @@
// bppc_open: raster scan with a two-pixel border, 3x3 erode then dilate on line memories
// depends on bppc_pkg; reads bppc_fifo, hands frame totals to bppc_class
`timescale 1ns / 1ps

module bppc_open import bppc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int SW = $clog2(MAX_WIDTH + 1),
    localparam int SH = $clog2(MAX_HEIGHT + 1),
    localparam int DW = SW + SH + 2,
    localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  logic [DW-1:0] q_data,
    output logic          q_pop,
    input  logic          result_taken,
    output logic          frame_end,
    output logic [CW-1:0] open_total,
    output logic [CW-1:0] dark_total,
    output logic [SW-1:0] frame_w,
    output logic [SH-1:0] frame_h
);

    localparam int XW = $clog2(MAX_WIDTH + 2);
    localparam int XH = $clog2(MAX_HEIGHT + 2);
    localparam int MD = MAX_WIDTH + 2;

    logic mask_a_mem [MD];
    logic mask_b_mem [MD];
    logic ero_a_mem  [MD];
    logic ero_b_mem  [MD];

    // stage a: scan position and pixel fetch
    logic [XH-1:0] r_reg;
    logic [XW-1:0] c_reg;
    logic          wait_reg;
    logic [SW-1:0] w_reg;
    logic [SH-1:0] h_reg;
    logic [CW-1:0] dark_reg;
    logic          q_bright, q_dark, first, need, go, pix, row_end, last;
    logic [SW-1:0] q_w, cur_w;
    logic [SH-1:0] q_h, cur_h;

    // stage b
    logic          b_v_reg, b_m_reg, b_last_reg;
    logic [XH-1:0] b_r_reg;
    logic [XW-1:0] b_c_reg;
    logic          ma_q_reg, mb_q_reg;
    logic [2:0]    mwin0_reg, mwin1_reg, mwin2_reg;

    // stage c
    logic          c_v_reg, c_last_reg;
    logic [XH-1:0] c_r_reg;
    logic [XW-1:0] c_c_reg;
    logic [2:0]    e_rows;
    logic          e_col1, e_col2, e_center, ero;

    // stage d
    logic          d_v_reg, d_e_reg, d_last_reg;
    logic [XH-1:0] d_r_reg;
    logic [XW-1:0] d_c_reg;
    logic          ea_q_reg, eb_q_reg;
    logic [2:0]    dwin0_reg, dwin1_reg, dwin2_reg;

    // stage e
    logic          e_v_reg, e_last_reg;
    logic [XH-1:0] e_r_reg;
    logic [XW-1:0] e_c_reg;
    logic [2:0]    o_rows;
    logic          o_col1, o_col2, opened, inc;
    logic [CW-1:0] open_reg, open_next;
    logic          frame_end_reg;

    assign q_bright = q_data[0];
    assign q_dark   = q_data[1];
    assign q_w      = q_data[SW+1:2];
    assign q_h      = q_data[DW-1:SW+2];

    assign first   = (r_reg == '0) && (c_reg == '0);
    assign cur_w   = first ? q_w : w_reg;
    assign cur_h   = first ? q_h : h_reg;
    assign need    = first || ((r_reg < XH'(cur_h)) && (c_reg < XW'(cur_w)));
    assign go      = !wait_reg && (!need || q_valid);
    assign q_pop   = go && need;
    assign pix     = need ? q_bright : 1'b1;
    assign row_end = c_reg == XW'(cur_w) + XW'(1);
    assign last    = row_end && (r_reg == XH'(cur_h) + XH'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_reg    <= '0;
            c_reg    <= '0;
            wait_reg <= 1'b0;
        end else begin
            if (go) begin
                if (row_end) begin
                    c_reg <= '0;
                    r_reg <= last ? '0 : r_reg + XH'(1);
                end else begin
                    c_reg <= c_reg + XW'(1);
                end
            end
            if (go && last) begin
                wait_reg <= 1'b1;
            end else if (result_taken) begin
                wait_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            w_reg    <= cur_w;
            h_reg    <= cur_h;
            dark_reg <= (first ? '0 : dark_reg) + CW'(q_pop && q_dark);
        end
        ma_q_reg   <= mask_a_mem[c_reg];
        mb_q_reg   <= mask_b_mem[c_reg];
        b_m_reg    <= pix;
        b_r_reg    <= r_reg;
        b_c_reg    <= c_reg;
        b_last_reg <= last;
    end

    // stage b: line memory update and mask window shift
    always_ff @(posedge aclk) begin
        if (b_v_reg) begin
            mask_a_mem[b_c_reg] <= b_m_reg;
            mask_b_mem[b_c_reg] <= ma_q_reg;
            mwin2_reg <= mwin1_reg;
            mwin1_reg <= mwin0_reg;
            mwin0_reg <= {mb_q_reg, ma_q_reg, b_m_reg};
        end
        c_r_reg    <= b_r_reg;
        c_c_reg    <= b_c_reg;
        c_last_reg <= b_last_reg;
    end

    // stage c: erode, neighbours outside the image read as set
    assign e_rows   = {c_r_reg >= XH'(2), c_r_reg != '0, 1'b1};
    assign e_col1   = c_c_reg != '0;
    assign e_col2   = c_c_reg >= XW'(2);
    assign e_center = (c_r_reg != '0) && (c_r_reg <= XH'(h_reg))
                   && (c_c_reg != '0) && (c_c_reg <= XW'(w_reg));
    assign ero      = e_center
                   && (&(mwin0_reg | ~e_rows))
                   && (&(mwin1_reg | ~(e_rows & {3{e_col1}})))
                   && (&(mwin2_reg | ~(e_rows & {3{e_col2}})));

    always_ff @(posedge aclk) begin
        ea_q_reg   <= ero_a_mem[c_c_reg];
        eb_q_reg   <= ero_b_mem[c_c_reg];
        d_e_reg    <= ero;
        d_r_reg    <= c_r_reg;
        d_c_reg    <= c_c_reg;
        d_last_reg <= c_last_reg;
    end

    // stage d: eroded line memory update and window shift
    always_ff @(posedge aclk) begin
        if (d_v_reg) begin
            ero_a_mem[d_c_reg] <= d_e_reg;
            ero_b_mem[d_c_reg] <= ea_q_reg;
            dwin2_reg <= dwin1_reg;
            dwin1_reg <= dwin0_reg;
            dwin0_reg <= {eb_q_reg, ea_q_reg, d_e_reg};
        end
        e_r_reg    <= d_r_reg;
        e_c_reg    <= d_c_reg;
        e_last_reg <= d_last_reg;
    end

    // stage e: dilate and count
    assign o_rows = {e_r_reg >= XH'(2), e_r_reg != '0, 1'b1};
    assign o_col1 = e_c_reg != '0;
    assign o_col2 = e_c_reg >= XW'(2);
    assign opened = (|(dwin0_reg & o_rows))
                 || (|(dwin1_reg & o_rows & {3{o_col1}}))
                 || (|(dwin2_reg & o_rows & {3{o_col2}}));
    assign inc    = (e_r_reg >= XH'(2)) && (e_c_reg >= XW'(2)) && opened;
    assign open_next = ((e_r_reg == '0) && (e_c_reg == '0)) ? '0 : open_reg + CW'(inc);

    always_ff @(posedge aclk) begin
        if (e_v_reg) begin
            open_reg <= open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            d_v_reg       <= 1'b0;
            e_v_reg       <= 1'b0;
            frame_end_reg <= 1'b0;
        end else begin
            b_v_reg       <= go;
            c_v_reg       <= b_v_reg;
            d_v_reg       <= c_v_reg;
            e_v_reg       <= d_v_reg;
            frame_end_reg <= e_v_reg && e_last_reg;
        end
    end

    assign frame_end  = frame_end_reg;
    assign open_total = open_reg;
    assign dark_total = dark_reg;
    assign frame_w    = w_reg;
    assign frame_h    = h_reg;

endmodule

@@ rtl/core/bppc_class.sv @@
// bppc_class: fraction tests on the frame totals and the result output register
// depends on bppc_pkg; fed by bppc_open
`timescale 1ns / 1ps

module bppc_class import bppc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int SW = $clog2(MAX_WIDTH + 1),
    localparam int SH = $clog2(MAX_HEIGHT + 1),
    localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               frame_end,
    input  logic [CW-1:0]      open_total,
    input  logic [CW-1:0]      dark_total,
    input  logic [SW-1:0]      frame_w,
    input  logic [SH-1:0]      frame_h,
    input  logic [LIMIT_W-1:0] dark_limit,
    input  logic [LIMIT_W-1:0] cue_limit,
    input  logic [LIMIT_W-1:0] stripe_limit,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata
);

    localparam int PW = CW + LIMIT_W;

    cls_state_t state_reg, state_next;

    logic [CW-1:0]     open_reg, dark_reg, area_reg;
    logic [PW-1:0]     prod_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [PW-1:0]     open_scaled, dark_scaled;

    assign open_scaled = {open_reg, {LIMIT_W{1'b0}}};
    assign dark_scaled = {dark_reg, {LIMIT_W{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CLS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CLS_IDLE:    if (frame_end) state_next = CLS_AREA;
            CLS_AREA:    state_next = CLS_PDARK;
            CLS_PDARK:   state_next = CLS_TDARK;
            CLS_TDARK:   state_next = (dark_scaled > prod_reg) ? CLS_HOLD : CLS_TCUE;
            CLS_TCUE:    state_next = (open_scaled > prod_reg) ? CLS_HOLD : CLS_TSTRIPE;
            CLS_TSTRIPE: state_next = CLS_HOLD;
            CLS_HOLD:    if (m_tready) state_next = CLS_IDLE;
            default:     state_next = CLS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            CLS_IDLE: begin
                open_reg <= open_total;
                dark_reg <= dark_total;
            end
            CLS_AREA: area_reg <= CW'(frame_w) * CW'(frame_h);
            CLS_PDARK: prod_reg <= PW'(dark_limit) * PW'(area_reg);
            CLS_TDARK: begin
                kind_reg <= KIND_EIGHT;
                prod_reg <= PW'(cue_limit) * PW'(area_reg);
            end
            CLS_TCUE: begin
                kind_reg <= KIND_CUE;
                prod_reg <= PW'(stripe_limit) * PW'(area_reg);
            end
            CLS_TSTRIPE: kind_reg <= (open_scaled > prod_reg) ? KIND_STRIPED : KIND_SOLID;
            default: ;
        endcase
    end

    assign m_tvalid = state_reg == CLS_HOLD;
    assign m_tdata  = {4'b0, TOTAL_W'(dark_reg), TOTAL_W'(open_reg), kind_reg};

endmodule

@@ rtl/core/ball_patch_pixel_classifier.sv @@
// ball_patch_pixel_classifier: top level, configuration registers and block wiring
// depends on bppc_pkg, bppc_front, bppc_fifo, bppc_open, bppc_class
//
// Pixel words enter on the s_ stream channel in raster order, one frame of
// frame_width x frame_height pixels; the size is taken on the first pixel of
// each frame. One result word leaves on the m_ channel per frame: ball kind,
// bright pixels left after a 3x3 opening and the dark pixel count.
// The opening engine scans each frame with a two-pixel border on the right
// and bottom, one position per cycle while the queue holds its pixels;
// a frame's (W+2)*(H+2) positions pass stages a to e, then classification
// computes the area, then one limit times area product per cycle.
// Pixels are taken at up to one per cycle while the 4-word queue in front of
// the engine has room. The result stays in its output register until taken;
// the engine starts the next frame only after that, while the front keeps
// filling the queue. A stalled receiver therefore stalls s_tready once the
// queue is full. Reset loads the register defaults and clears the position
// counters; the line memories need no clearing.
// Configuration writes use cfg_we, cfg_idx and cfg_data, one register per write.
`timescale 1ns / 1ps

module ball_patch_pixel_classifier import bppc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,  // chan_blue, chan_green, chan_red
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,  // ball_kind, opened_bright_total, dark_total
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SW = $clog2(MAX_WIDTH + 1);
    localparam int SH = $clog2(MAX_HEIGHT + 1);
    localparam int DW = SW + SH + 2;
    localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    logic [SIZE_CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [LEVEL_W-1:0]    bright_level_reg, dark_level_reg;
    logic [LIMIT_W-1:0]    dark_limit_reg, cue_limit_reg, stripe_limit_reg;

    logic          q_push, q_ready, q_valid, q_pop;
    logic [DW-1:0] q_wdata, q_rdata;
    logic          frame_end;
    logic [CW-1:0] open_total, dark_total;
    logic [SW-1:0] frame_w;
    logic [SH-1:0] frame_h;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            bright_level_reg <= RST_BRIGHT_LEVEL;
            dark_level_reg   <= RST_DARK_LEVEL;
            dark_limit_reg   <= RST_DARK_LIMIT;
            cue_limit_reg    <= RST_CUE_LIMIT;
            stripe_limit_reg <= RST_STRIPE_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[SIZE_CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SIZE_CFG_W-1:0];
                REG_BRIGHT_LEVEL: bright_level_reg <= cfg_data[LEVEL_W-1:0];
                REG_DARK_LEVEL:   dark_level_reg   <= cfg_data[LEVEL_W-1:0];
                REG_DARK_LIMIT:   dark_limit_reg   <= cfg_data;
                REG_CUE_LIMIT:    cue_limit_reg    <= cfg_data;
                REG_STRIPE_LIMIT: stripe_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bppc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .bright_level (bright_level_reg),
        .dark_level   (dark_level_reg),
        .q_push       (q_push),
        .q_ready      (q_ready),
        .q_data       (q_wdata)
    );

    bppc_fifo #(
        .DW (DW)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .ready   (q_ready),
        .wdata   (q_wdata),
        .valid   (q_valid),
        .pop     (q_pop),
        .rdata   (q_rdata)
    );

    bppc_open #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_open (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .result_taken (m_tvalid && m_tready),
        .frame_end    (frame_end),
        .open_total   (open_total),
        .dark_total   (dark_total),
        .frame_w      (frame_w),
        .frame_h      (frame_h)
    );

    bppc_class #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_class (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .frame_end    (frame_end),
        .open_total   (open_total),
        .dark_total   (dark_total),
        .frame_w      (frame_w),
        .frame_h      (frame_h),
        .dark_limit   (dark_limit_reg),
        .cue_limit    (cue_limit_reg),
        .stripe_limit (stripe_limit_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
